### sv/fcct_pkg.sv
package fcct_pkg;

  // Default number of channels.
  localparam int NUM_CHANNELS_DEF = 4;

  // Operation codes carried in the opcode field.
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_TRIG  = 3'd3;
  localparam logic [2:0] OP_ACK   = 3'd4;

  // Bit positions in the 9-bit channel mode word.
  localparam int MB_INT  = 7;
  localparam int MB_CNT  = 6;
  localparam int MB_PRE  = 5;
  localparam int MB_EDGE = 4;
  localparam int MB_TRIG = 3;
  localparam int MB_TC   = 2;
  localparam int MB_RST  = 1;
  localparam int MB_CTRL = 0;
  localparam int MB_WAIT = 8;

  // Number of quotient bits walked by the remainder unit.
  localparam int DIV_STEPS = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic tick_sub;
    logic div_init;
    logic div_step;
    logic tick_wrap;
    logic load_out;
  } fcct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic ch_running;
    logic ch_wrap;
  } fcct_sts_t;

  // Effective time constant: zero stands for 256.
  function automatic logic [8:0] tc_of_f(input logic [8:0] tc);
    return (tc == 9'd0) ? 9'h100 : tc;
  endfunction

  // Period in cycles of one full count.
  function automatic logic [16:0] period_f(input logic [8:0] mode, input logic [8:0] tc);
    logic [8:0] t;
    t = tc_of_f(tc);
    if (mode[MB_CNT]) begin
      return {8'd0, t};
    end else if (mode[MB_PRE]) begin
      return {t, 8'd0};
    end
    return {4'd0, t, 4'd0};
  endfunction

  // Remaining prescaled count, rounded up and clamped to 1..256.
  function automatic logic [8:0] remain_f(input logic [17:0] cl, input logic [8:0] mode);
    logic [18:0] s;
    logic [18:0] r;
    s = {1'b0, cl} + (mode[MB_PRE] ? 19'd255 : 19'd15);
    r = mode[MB_PRE] ? (s >> 8) : (s >> 4);
    if (r == 19'd0) begin
      return 9'd1;
    end else if (r > 19'd256) begin
      return 9'h100;
    end
    return r[8:0];
  endfunction

endpackage

### sv/four_channel_counter_timer_core.sv
// Counter/timer with NUM_CHANNELS down-counting channels.
// Input words arrive on in_t*: each carries one operation (register write,
// count read, tick that advances the channels by tick_cycles, trigger pin level, or
// interrupt acknowledge). Every accepted word yields exactly one output word
// on out_t* with the read data, the acknowledge vector, the interrupt line
// and the pending bits as they stand after the operation.
// One word is worked at a time. A write, read, trigger or acknowledge is
// latched, executed and loaded into the output register. A nonzero tick
// also scans the channels in turn; a running channel at terminal count has
// its overshoot reduced by its period in a one-bit-per-cycle remainder unit.
// The finished word sits in an output register, so a new input word is
// taken while the previous result still waits; if the receiver stalls, the
// next result waits in the last state until the output register frees up.
// After the synchronous reset all channels are stopped with zero registers,
// nothing is pending, and the trigger pin of channel 3 reads high.
module four_channel_counter_timer_core #(
  parameter int NUM_CHANNELS = fcct_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // opcode[2:0], channel[4:3], write_data[12:5],
                                  // tick_cycles[28:13], trigger_level[29]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // read_data[7:0], vector_out[15:8],
                                  // irq_request[16], pending_mask[20:17]
);
  import fcct_pkg::*;

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  fcct_cmd_t     cmd;
  fcct_sts_t     sts;
  logic [CW-1:0] scan_idx;

  // Sequencer.
  fcct_ctrl #(.NUM_CHANNELS(NUM_CHANNELS), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .scan_idx   (scan_idx)
  );

  // Channel registers and arithmetic.
  fcct_dp #(.NUM_CHANNELS(NUM_CHANNELS), .CW(CW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .scan_idx  (scan_idx),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

### sv/fcct_ctrl.sv
module fcct_ctrl #(
  parameter int NUM_CHANNELS = fcct_pkg::NUM_CHANNELS_DEF,
  parameter int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  fcct_pkg::fcct_sts_t sts,
  output fcct_pkg::fcct_cmd_t cmd,
  output logic [CW-1:0]       scan_idx
);
  import fcct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_DIV, S_WRAP, S_FIN
  } state_t;

  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CHANNELS - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          ovalid_r, ovalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign scan_idx   = idx_r;

  // Sequencing of one item.
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r & ~out_tready;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        idx_nxt  = '0;
        state_nxt = sts.is_tick ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        if (sts.ch_running && sts.ch_wrap) begin
          cmd.div_init = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cmd.tick_sub = sts.ch_running;
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'(DIV_STEPS - 1)) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.tick_wrap = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_FIN: begin
        if (!ovalid_r || out_tready) begin
          cmd.load_out = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

### sv/fcct_dp.sv
module fcct_dp #(
  parameter int NUM_CHANNELS = fcct_pkg::NUM_CHANNELS_DEF,
  parameter int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         in_tdata,  // opcode, channel, write_data, tick_cycles, trigger_level
  input  fcct_pkg::fcct_cmd_t cmd,
  input  logic [CW-1:0]       scan_idx,
  output fcct_pkg::fcct_sts_t sts,
  output logic [23:0]         out_tdata  // read_data, vector_out, irq_request, pending_mask
);
  import fcct_pkg::*;

  // Latched input word.
  logic [2:0]  op_r, op_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [15:0] cyc_r, cyc_nxt;
  logic        lvl_r, lvl_nxt;

  // Channel state.
  logic [7:0]  vbase_r, vbase_nxt;
  logic [8:0]  mode_r [NUM_CHANNELS];
  logic [8:0]  mode_nxt [NUM_CHANNELS];
  logic [8:0]  tc_r [NUM_CHANNELS];
  logic [8:0]  tc_nxt [NUM_CHANNELS];
  logic [8:0]  dc_r [NUM_CHANNELS];
  logic [8:0]  dc_nxt [NUM_CHANNELS];
  logic [17:0] cl_r [NUM_CHANNELS];
  logic [17:0] cl_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] run_r, run_nxt;
  logic [NUM_CHANNELS-1:0] pin_r, pin_nxt;
  logic [NUM_CHANNELS-1:0] pend_r, pend_nxt;

  // Result and remainder unit.
  logic [7:0]  rd_r, rd_nxt;
  logic [7:0]  vec_r, vec_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [23:0] out_r, out_nxt;

  logic [CW-1:0] ci;
  logic          ch_ok;
  logic [8:0]    m;
  logic [8:0]    tcv;
  logic [8:0]    dcv;
  logic [17:0]   clv;
  logic [17:0]   t18;
  logic [16:0]   per;
  logic          act;
  logic          found;
  logic [CW-1:0] fi;

  assign ci    = CW'(ch_r);
  assign ch_ok = (int'(ch_r) < NUM_CHANNELS);

  // Status for the channel being scanned.
  assign sts.is_tick    = (op_r == OP_TICK) && (cyc_r != 16'd0);
  assign sts.ch_running = run_r[scan_idx];
  assign sts.ch_wrap    = (cl_r[scan_idx] <= {2'd0, cyc_r});

  assign out_tdata = out_r;

  always_comb begin
    op_nxt    = op_r;
    ch_nxt    = ch_r;
    data_nxt  = data_r;
    cyc_nxt   = cyc_r;
    lvl_nxt   = lvl_r;
    vbase_nxt = vbase_r;
    mode_nxt  = mode_r;
    tc_nxt    = tc_r;
    dc_nxt    = dc_r;
    cl_nxt    = cl_r;
    run_nxt   = run_r;
    pin_nxt   = pin_r;
    pend_nxt  = pend_r;
    rd_nxt    = rd_r;
    vec_nxt   = vec_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    out_nxt   = out_r;
    m         = mode_r[ci];
    tcv       = '0;
    dcv       = '0;
    clv       = '0;
    t18       = '0;
    per       = '0;
    act       = 1'b0;
    found     = 1'b0;
    fi        = '0;

    // Capture a new input word.
    if (cmd.latch) begin
      op_nxt   = in_tdata[2:0];
      ch_nxt   = in_tdata[4:3];
      data_nxt = in_tdata[12:5];
      cyc_nxt  = in_tdata[28:13];
      lvl_nxt  = in_tdata[29];
      rd_nxt   = '0;
      vec_nxt  = '0;
    end

    // Operations worked in the execute step.
    if (cmd.exec) begin
      unique case (op_r)
        OP_WRITE: begin
          if (ch_ok) begin
            if (m[MB_TC]) begin
              tcv = (data_r == 8'd0) ? 9'h100 : {1'b0, data_r};
              tc_nxt[ci] = tcv;
              dc_nxt[ci] = tcv;
              m[MB_TC]  = 1'b0;
              m[MB_RST] = 1'b0;
              if (m[MB_CNT] || !m[MB_TRIG]) begin
                m[MB_WAIT] = 1'b0;
                if (m[MB_CNT]) begin
                  run_nxt[ci] = 1'b0;
                end else begin
                  cl_nxt[ci]  = {1'b0, period_f(m, tcv)};
                  run_nxt[ci] = 1'b1;
                end
              end else begin
                m[MB_WAIT]  = 1'b1;
                run_nxt[ci] = 1'b0;
              end
              mode_nxt[ci] = m;
            end else if (!data_r[MB_CTRL]) begin
              if (ch_r == 2'd0) begin
                vbase_nxt = data_r & 8'hF8;
              end
            end else begin
              if (data_r[MB_RST]) begin
                run_nxt[ci] = 1'b0;
              end
              mode_nxt[ci] = {1'b0, data_r};
              if (!data_r[MB_INT]) begin
                pend_nxt[ci] = 1'b0;
              end
            end
          end
        end
        OP_READ: begin
          if (ch_ok) begin
            // A count of 256 reads back as zero.
            dcv    = run_r[ci] ? remain_f(cl_r[ci], m) : dc_r[ci];
            rd_nxt = dcv[7:0];
          end
        end
        OP_TRIG: begin
          if (ch_ok && (lvl_r != pin_r[ci])) begin
            pin_nxt[ci] = lvl_r;
            act = m[MB_EDGE] ? lvl_r : ~lvl_r;
            if (act) begin
              if (m[MB_WAIT] && !m[MB_CNT]) begin
                m[MB_WAIT] = 1'b0;
                mode_nxt[ci] = m;
                if (m[MB_RST]) begin
                  run_nxt[ci] = 1'b0;
                end else begin
                  cl_nxt[ci]  = {1'b0, period_f(m, tc_r[ci])};
                  run_nxt[ci] = 1'b1;
                end
              end else if (m[MB_CNT]) begin
                dcv = (dc_r[ci] == 9'd0) ? tc_of_f(tc_r[ci]) : dc_r[ci];
                dcv = dcv - 9'd1;
                if (dcv == 9'd0) begin
                  if (m[MB_INT]) begin
                    pend_nxt[ci] = 1'b1;
                  end
                  dcv = tc_of_f(tc_r[ci]);
                end
                dc_nxt[ci] = dcv;
              end
            end
          end
        end
        OP_ACK: begin
          for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (pend_r[i]) begin
              found = 1'b1;
              fi    = CW'(i);
            end
          end
          if (found) begin
            pend_nxt[fi] = 1'b0;
            vec_nxt = vbase_r | 8'({fi, 1'b0});
          end else begin
            vec_nxt = vbase_r;
          end
        end
        default: begin
        end
      endcase
    end

    // Tick without terminal count on the scanned channel.
    if (cmd.tick_sub) begin
      clv = cl_r[scan_idx] - {2'd0, cyc_r};
      cl_nxt[scan_idx] = clv;
      if (!mode_r[scan_idx][MB_CNT]) begin
        dc_nxt[scan_idx] = remain_f(clv, mode_r[scan_idx]);
      end
    end

    // Remainder of the overshoot by the period, one bit a cycle.
    if (cmd.div_init) begin
      rem_nxt = '0;
      quo_nxt = cyc_r - cl_r[scan_idx][15:0];
    end
    if (cmd.div_step) begin
      per = period_f(mode_r[scan_idx], tc_r[scan_idx]);
      t18 = {rem_r, quo_r[15]};
      if (t18 >= {1'b0, per}) begin
        t18 = t18 - {1'b0, per};
      end
      rem_nxt = t18[16:0];
      quo_nxt = {quo_r[14:0], 1'b0};
    end

    // Terminal count: reload and keep the phase.
    if (cmd.tick_wrap) begin
      per = period_f(mode_r[scan_idx], tc_r[scan_idx]);
      if (mode_r[scan_idx][MB_INT]) begin
        pend_nxt[scan_idx] = 1'b1;
      end
      clv = {1'b0, per} - {1'b0, rem_r};
      cl_nxt[scan_idx] = clv;
      if (mode_r[scan_idx][MB_CNT]) begin
        dc_nxt[scan_idx] = tc_r[scan_idx];
      end else begin
        dc_nxt[scan_idx] = remain_f(clv, mode_r[scan_idx]);
      end
    end

    // Result word.
    if (cmd.load_out) begin
      out_nxt = {3'd0, 4'(pend_r), |pend_r, vec_r, rd_r};
    end
  end

  // Control and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbase_r <= '0;
      run_r   <= '0;
      pend_r  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mode_r[i] <= '0;
        tc_r[i]   <= '0;
        dc_r[i]   <= '0;
        cl_r[i]   <= '0;
        pin_r[i]  <= (i == 3);
      end
    end else begin
      vbase_r <= vbase_nxt;
      run_r   <= run_nxt;
      pend_r  <= pend_nxt;
      pin_r   <= pin_nxt;
      mode_r  <= mode_nxt;
      tc_r    <= tc_nxt;
      dc_r    <= dc_nxt;
      cl_r    <= cl_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    ch_r   <= ch_nxt;
    data_r <= data_nxt;
    cyc_r  <= cyc_nxt;
    lvl_r  <= lvl_nxt;
    rd_r   <= rd_nxt;
    vec_r  <= vec_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    out_r  <= out_nxt;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

// Scoreboard: predicts each result word of the counter/timer and checks
// the words that come out against the oldest prediction.
class ctc_scoreboard;
  logic [7:0]  vec_base;
  logic [8:0]  mode [4];
  logic [8:0]  tconst [4];
  logic [8:0]  dcount [4];
  logic [17:0] cyc_left [4];
  logic        running [4];
  logic        pin [4];
  logic [3:0]  pend;
  logic [23:0] expected_q [$];
  int          errors;
  int          checked;

  function new();
    vec_base = '0;
    pend = '0;
    for (int i = 0; i < 4; i++) begin
      mode[i] = '0;
      tconst[i] = '0;
      dcount[i] = '0;
      cyc_left[i] = '0;
      running[i] = 1'b0;
      pin[i] = (i == 3);
    end
    errors = 0;
    checked = 0;
  endfunction

  function int eff_tc(int ch);
    return (tconst[ch] == 0) ? 256 : int'(tconst[ch]);
  endfunction

  function int prescale(int ch);
    return mode[ch][fcct_pkg::MB_PRE] ? 256 : 16;
  endfunction

  function int period(int ch);
    return mode[ch][fcct_pkg::MB_CNT] ? eff_tc(ch) : eff_tc(ch) * prescale(ch);
  endfunction

  function int remaining(int ch);
    int p;
    int r;
    p = prescale(ch);
    r = (int'(cyc_left[ch]) + p - 1) / p;
    if (r < 1) r = 1;
    if (r > 256) r = 256;
    return r;
  endfunction

  function void raise(int ch);
    if (mode[ch][fcct_pkg::MB_INT]) pend[ch] = 1'b1;
  endfunction

  function void start(int ch);
    if (mode[ch][fcct_pkg::MB_CNT] || mode[ch][fcct_pkg::MB_RST] ||
        mode[ch][fcct_pkg::MB_WAIT]) begin
      running[ch] = 1'b0;
    end else begin
      cyc_left[ch] = 18'(period(ch));
      running[ch] = 1'b1;
    end
  endfunction

  function void reg_write(int ch, logic [7:0] d);
    if (mode[ch][fcct_pkg::MB_TC]) begin
      tconst[ch] = (d == 0) ? 9'h100 : {1'b0, d};
      dcount[ch] = tconst[ch];
      mode[ch][fcct_pkg::MB_TC] = 1'b0;
      mode[ch][fcct_pkg::MB_RST] = 1'b0;
      if (mode[ch][fcct_pkg::MB_CNT] || !mode[ch][fcct_pkg::MB_TRIG]) begin
        mode[ch][fcct_pkg::MB_WAIT] = 1'b0;
        start(ch);
      end else begin
        mode[ch][fcct_pkg::MB_WAIT] = 1'b1;
        running[ch] = 1'b0;
      end
    end else if (!d[fcct_pkg::MB_CTRL]) begin
      if (ch == 0) vec_base = d & 8'hF8;
    end else begin
      if (d[fcct_pkg::MB_RST]) running[ch] = 1'b0;
      mode[ch] = {1'b0, d};
      if (!d[fcct_pkg::MB_INT]) pend[ch] = 1'b0;
    end
  endfunction

  function void advance(int cycles);
    int c;
    int per;
    if (cycles == 0) return;
    for (int ch = 0; ch < 4; ch++) begin
      if (!running[ch]) continue;
      c = cyc_left[ch];
      per = period(ch);
      if (c > cycles) begin
        cyc_left[ch] = 18'(c - cycles);
      end else begin
        raise(ch);
        dcount[ch] = tconst[ch];
        cyc_left[ch] = 18'(per - ((cycles - c) % per));
      end
      if (!mode[ch][fcct_pkg::MB_CNT]) dcount[ch] = 9'(remaining(ch));
    end
  endfunction

  function void trigger(int ch, logic lvl);
    logic active;
    if (lvl == pin[ch]) return;
    pin[ch] = lvl;
    active = mode[ch][fcct_pkg::MB_EDGE] ? lvl : !lvl;
    if (!active) return;
    if (mode[ch][fcct_pkg::MB_WAIT] && !mode[ch][fcct_pkg::MB_CNT]) begin
      mode[ch][fcct_pkg::MB_WAIT] = 1'b0;
      start(ch);
    end else if (mode[ch][fcct_pkg::MB_CNT]) begin
      if (dcount[ch] == 0) dcount[ch] = 9'(eff_tc(ch));
      dcount[ch] = dcount[ch] - 9'd1;
      if (dcount[ch] == 0) begin
        raise(ch);
        dcount[ch] = 9'(eff_tc(ch));
      end
    end
  endfunction

  // Note one accepted input word and queue the result it must produce.
  function void note_input(logic [31:0] w);
    logic [2:0]  op;
    int          ch;
    logic [7:0]  rd;
    logic [7:0]  vec;
    op = w[2:0];
    ch = w[4:3];
    rd = '0;
    vec = '0;
    case (op)
      fcct_pkg::OP_WRITE: reg_write(ch, w[12:5]);
      fcct_pkg::OP_READ: begin
        if (running[ch]) rd = 8'(remaining(ch));
        else rd = dcount[ch][7:0];
      end
      fcct_pkg::OP_TICK: advance(w[28:13]);
      fcct_pkg::OP_TRIG: trigger(ch, w[29]);
      fcct_pkg::OP_ACK: begin
        vec = vec_base;
        for (int i = 0; i < 4; i++) begin
          if (pend[i]) begin
            pend[i] = 1'b0;
            vec = vec_base | 8'(i << 1);
            break;
          end
        end
      end
      default: ;
    endcase
    expected_q.push_back({3'b0, pend, |pend, vec, rd});
  endfunction

  task report(string what, logic [23:0] got, logic [23:0] want);
    errors++;
    if (errors <= 30) $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // Check one result word against the oldest prediction, field by field.
  task check_result(logic [23:0] got);
    logic [23:0] want;
    checked++;
    if (expected_q.size() == 0) begin
      report("unexpected word", got, '0);
      return;
    end
    want = expected_q.pop_front();
    if (got[7:0] != want[7:0]) report("read_data", got, want);
    if (got[15:8] != want[15:8]) report("vector_out", got, want);
    if (got[16] != want[16]) report("irq_request", got, want);
    if (got[20:17] != want[20:17]) report("pending_mask", got, want);
  endtask
endclass

module testbench;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  ctc_scoreboard sb;
  int          stall_mode = 0;
  int          stall_left = 0;
  int          sent = 0;

  four_channel_counter_timer_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pack(logic [2:0] op, logic [1:0] ch, logic [7:0] d,
                                       logic [15:0] cyc, logic lvl);
    return {2'b0, lvl, cyc, d, ch, op};
  endfunction

  // Present one word, hold it until it is taken, then maybe idle.
  task automatic send_word(logic [31:0] w);
    int g;
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    sb.note_input(w);
    sent++;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Result side: always ready, or in stall mode random stalls, mostly short with an occasional long one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (stall_mode == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 4) begin
      stall_left = $urandom_range(8, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Random control word biased toward useful settings.
  function automatic logic [7:0] rand_ctrl();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    c[fcct_pkg::MB_CTRL] = 1'b1;
    if ($urandom_range(0, 3) != 0) c[fcct_pkg::MB_TC] = 1'b1;
    if ($urandom_range(0, 3) != 0) c[fcct_pkg::MB_RST] = 1'b0;
    return c;
  endfunction

  initial begin
    logic [31:0] w;
    logic [1:0]  ch;
    int          kind;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads after reset, zero constant, vectors, every defined opcode and two undefined ones.
    send_word(pack(fcct_pkg::OP_READ, 2'd0, 8'h00, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_ACK, 2'd0, 8'h00, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd0, 8'hFE, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd1, 8'h50, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd0, 8'h85, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd0, 8'h00, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_READ, 2'd0, 8'h00, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_TICK, 2'd0, 8'h00, 16'hFFFF, 1'b1));
    send_word(pack(fcct_pkg::OP_TICK, 2'd0, 8'h00, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_READ, 2'd0, 8'h00, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd2, 8'hD5, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd2, 8'h01, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_TRIG, 2'd2, 8'h00, 16'h0000, 1'b1));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd3, 8'hAD, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd3, 8'hFF, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_TRIG, 2'd3, 8'h00, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_TRIG, 2'd3, 8'h00, 16'h0000, 1'b1));
    send_word(pack(fcct_pkg::OP_WRITE, 2'd0, 8'hE1, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_TICK, 2'd0, 8'h00, 16'd5000, 1'b0));
    send_word(pack(fcct_pkg::OP_ACK, 2'd0, 8'h00, 16'h0000, 1'b0));
    send_word(pack(fcct_pkg::OP_ACK, 2'd0, 8'h00, 16'h0000, 1'b0));
    send_word(pack(3'd7, 2'd1, 8'hFF, 16'hFFFF, 1'b1));
    send_word(pack(3'd5, 2'd0, 8'h00, 16'h0000, 1'b0));
    drain();

    // Random: programming sequences mixed with random traffic.
    for (int n = 0; n < 1200; n++) begin
      if (n % 300 == 150) drain();
      if (n % 200 == 0) stall_mode = $urandom_range(0, 1);
      ch = 2'($urandom_range(0, 3));
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        w = pack(fcct_pkg::OP_WRITE, ch, rand_ctrl(), 16'($urandom), 1'($urandom));
        send_word(w);
        // A control word that announces a time constant is followed by one.
        if (w[5 + fcct_pkg::MB_TC]) begin
          send_word(pack(fcct_pkg::OP_WRITE, ch,
                         8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 6)),
                         16'($urandom), 1'($urandom)));
          n++;
        end
      end else if (kind < 16) begin
        send_word(pack(fcct_pkg::OP_WRITE, ch, 8'($urandom), 16'($urandom),
                       1'($urandom)));
      end else if (kind < 34) begin
        send_word(pack(fcct_pkg::OP_READ, ch, 8'($urandom), 16'($urandom),
                       1'($urandom)));
      end else if (kind < 56) begin
        send_word(pack(fcct_pkg::OP_TICK, ch, 8'($urandom),
                       16'(($urandom_range(0, 4) == 0) ? $urandom
                                                       : $urandom_range(0, 400)),
                       1'($urandom)));
      end else if (kind < 86) begin
        send_word(pack(fcct_pkg::OP_TRIG, ch, 8'($urandom), 16'($urandom),
                       1'($urandom)));
      end else if (kind < 97) begin
        send_word(pack(fcct_pkg::OP_ACK, ch, 8'($urandom), 16'($urandom),
                       1'($urandom)));
      end else begin
        send_word(pack(3'($urandom_range(5, 7)), ch, 8'($urandom), 16'($urandom),
                       1'($urandom)));
      end
    end

    in_tvalid <= 1'b0;
    stall_mode = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d words covering writes, reads, ticks, triggers and acknowledges;",
             sent);
    $display("checked %0d result words with random stalls on both sides.", sb.checked);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
